// ----- design/lbpt_pkg.sv -----
`default_nettype none
package lbpt_pkg;
   localparam int SLOTS_DEFAULT = 16;
   localparam int CMD_W = 2;
   localparam int FILE_W = 8;
   localparam int BLOCK_W = 24;
   localparam int STATUS_W = 4;
   localparam int SLOT_W = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ = 2'd0, CMD_WRITE = 2'd1, CMD_PIN = 2'd2, CMD_UNPIN = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_READ_HIT = 4'd0, ST_FILL_FREE = 4'd1, ST_REPL_CLEAN = 4'd2,
      ST_REPL_DIRTY = 4'd3, ST_ALL_PINNED = 4'd4, ST_WRITE_HIT = 4'd5,
      ST_WRITE_THRU = 4'd6, ST_DONE = 4'd7, ST_NOT_FOUND = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_UPDATE, S_RESP
   } state_type;
endpackage
`default_nettype wire

// ----- design/lbpt_if.sv -----
`default_nettype none
interface lbpt_req_if;
   import lbpt_pkg::*;
   logic valid;
   logic ready;
   logic [CMD_W-1:0] command;
   logic [FILE_W-1:0] file_id;
   logic [BLOCK_W-1:0] block_number;
   modport source (output valid, command, file_id, block_number, input ready);
   modport sink (input valid, command, file_id, block_number, output ready);
endinterface

interface lbpt_rsp_if;
   import lbpt_pkg::*;
   logic valid;
   logic ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0] slot;
   logic [FILE_W-1:0] victim_file;
   logic [BLOCK_W-1:0] victim_block;
   modport source (output valid, status, slot, victim_file, victim_block, input ready);
   modport sink (input valid, status, slot, victim_file, victim_block, output ready);
endinterface
`default_nettype wire

// ----- design/lbpt_tag_mem.sv -----
`default_nettype none
module lbpt_tag_mem
   import lbpt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
   input  wire logic [FILE_W+BLOCK_W-1:0] wr_data,
   input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
   output logic      [FILE_W+BLOCK_W-1:0] rd_data
);
   logic [FILE_W+BLOCK_W-1:0] mem [SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- design/lru_buffer_pool_tags.sv -----
// lru_buffer_pool_tags: tag and LRU policy engine of a block buffer pool.
// req channel: one beat carries command (read, write, pin, unpin), file_id
// and block_number. rsp channel: one beat per request with status, slot and,
// for a dirty replacement, the victim tag to write back.
// Tags live in a one-port-read synchronous memory. A request scans it one
// slot per cycle (read address, then compare on the registered data), then
// passes through S_UPDATE and S_RESP. One request is in flight at a time,
// so a new request is accepted only after the previous response is taken.
// Per-slot valid, pinned, dirty marks and recency ages sit in flip-flops
// beside the memory and are updated in the S_UPDATE state after the scan.
// The victim tag is read back from the memory during the scan.
// Reset clears valid, pinned and dirty marks; the pool is empty and the
// block accepts requests in the next cycle. No clearing pass is needed.
// When rsp stalls, the response is held and req stays not ready until the
// beat is taken.
`default_nettype none
module lru_buffer_pool_tags
   import lbpt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   lbpt_req_if.sink   req,
   lbpt_rsp_if.source rsp
);
   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int AW = $clog2(SLOTS);

   state_type state_ff, state_in;

   logic [CMD_W-1:0]   cmd_ff;
   logic [FILE_W-1:0]  file_ff;
   logic [BLOCK_W-1:0] block_ff;

   logic [SLOTS-1:0] valid_ff, pinned_ff, dirty_ff;
   logic [AW-1:0]    age_ff [SLOTS];

   // scan counters: rd_cnt issues reads, cmp_idx follows it in the next cycle
   logic [CW-1:0] rd_cnt_ff;
   logic [IW-1:0] cmp_idx_ff;
   logic          cmp_vld_ff;

   logic          hit_ff;
   logic [IW-1:0] hit_idx_ff;
   logic          victim_ff;
   logic [IW-1:0] victim_idx_ff;
   logic [FILE_W+BLOCK_W-1:0] victim_tag_ff;

   logic [STATUS_W-1:0] status_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [FILE_W-1:0]   vfile_ff;
   logic [BLOCK_W-1:0]  vblock_ff;

   logic                      mem_we;
   logic [IW-1:0]             mem_wa;
   logic [IW-1:0]             mem_ra;
   logic [FILE_W+BLOCK_W-1:0] mem_rd;

   lbpt_tag_mem #(.SLOTS(SLOTS)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_wa),
      .wr_data({file_ff, block_ff}), .rd_addr(mem_ra), .rd_data(mem_rd)
   );

   // Free and oldest-unpinned picks come from the flop-based marks.
   logic          free_any;
   logic [IW-1:0] free_idx;
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req.valid) state_in = S_SCAN;
         S_SCAN:   if (cmp_vld_ff && cmp_idx_ff == IW'(SLOTS - 1)) state_in = S_UPDATE;
         S_UPDATE: state_in = S_RESP;
         S_RESP:   if (rsp.ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req.ready = (state_ff == S_IDLE) && !reset;
      rsp.valid = (state_ff == S_RESP);
   end

   assign rsp.status       = status_ff;
   assign rsp.slot         = slot_ff;
   assign rsp.victim_file  = vfile_ff;
   assign rsp.victim_block = vblock_ff;

   assign mem_ra = rd_cnt_ff[IW-1:0];

   logic is_miss_read;
   logic do_fill, do_repl, do_touch;
   logic [IW-1:0] tgt;
   logic [AW-1:0] tgt_age;
   always_comb begin
      is_miss_read = (cmd_ff == CMD_READ) && !hit_ff;
      do_fill  = is_miss_read && free_any;
      do_repl  = is_miss_read && !free_any && victim_ff;
      tgt      = do_fill ? free_idx : (do_repl ? victim_idx_ff : hit_idx_ff);
      tgt_age  = age_ff[tgt];
      do_touch = ((cmd_ff == CMD_READ) && (hit_ff || do_repl)) ||
                 ((cmd_ff == CMD_UNPIN) && hit_ff);
      mem_we   = (state_ff == S_UPDATE) && (do_fill || do_repl);
      mem_wa   = tgt;
   end

   logic [STATUS_W-1:0] status_in;
   logic [SLOT_W-1:0]   slot_in;
   logic [FILE_W-1:0]   vfile_in;
   logic [BLOCK_W-1:0]  vblock_in;
   always_comb begin
      status_in = ST_NOT_FOUND;
      slot_in   = '0;
      vfile_in  = '0;
      vblock_in = '0;
      unique case (cmd_ff)
         CMD_READ: begin
            if (hit_ff) begin
               status_in = ST_READ_HIT;
               slot_in   = SLOT_W'(hit_idx_ff);
            end else if (do_fill) begin
               status_in = ST_FILL_FREE;
               slot_in   = SLOT_W'(tgt);
            end else if (do_repl) begin
               slot_in = SLOT_W'(tgt);
               if (dirty_ff[tgt]) begin
                  status_in = ST_REPL_DIRTY;
                  vfile_in  = victim_tag_ff[FILE_W+BLOCK_W-1:BLOCK_W];
                  vblock_in = victim_tag_ff[BLOCK_W-1:0];
               end else begin
                  status_in = ST_REPL_CLEAN;
               end
            end else begin
               status_in = ST_ALL_PINNED;
            end
         end
         CMD_WRITE: begin
            if (hit_ff) begin
               status_in = ST_WRITE_HIT;
               slot_in   = SLOT_W'(tgt);
            end else begin
               status_in = ST_WRITE_THRU;
            end
         end
         CMD_PIN, CMD_UNPIN: begin
            if (hit_ff) begin
               status_in = ST_DONE;
               slot_in   = SLOT_W'(tgt);
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: ;
      endcase
   end

   logic tag_match;
   assign tag_match = mem_rd == {file_ff, block_ff};

   // Victim chosen during scan from registered flags and ages.
   logic victim_better;
   assign victim_better = !pinned_ff[cmp_idx_ff] &&
      (!victim_ff || age_ff[cmp_idx_ff] > age_ff[victim_idx_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         pinned_ff  <= '0;
         dirty_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req.valid) begin
               cmd_ff    <= req.command;
               file_ff   <= req.file_id;
               block_ff  <= req.block_number;
               rd_cnt_ff <= '0;
               hit_ff    <= 1'b0;
               victim_ff <= 1'b0;
               hit_idx_ff <= '0;
               victim_idx_ff <= '0;
            end
            S_SCAN: begin
               if (rd_cnt_ff < CW'(SLOTS)) begin
                  cmp_idx_ff <= rd_cnt_ff[IW-1:0];
                  cmp_vld_ff <= 1'b1;
                  rd_cnt_ff  <= rd_cnt_ff + 1'b1;
               end
               if (cmp_vld_ff) begin
                  if (valid_ff[cmp_idx_ff] && tag_match && !hit_ff) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= cmp_idx_ff;
                  end
                  if (victim_better) begin
                     victim_ff     <= 1'b1;
                     victim_idx_ff <= cmp_idx_ff;
                     victim_tag_ff <= mem_rd;
                  end
               end
            end
            S_UPDATE: begin
               status_ff <= status_in;
               slot_ff   <= slot_in;
               vfile_ff  <= vfile_in;
               vblock_ff <= vblock_in;
               for (int i = 0; i < SLOTS; i++) begin
                  if (do_fill && valid_ff[i]) age_ff[i] <= age_ff[i] + 1'b1;
                  if (do_touch && valid_ff[i] && IW'(i) != tgt && age_ff[i] < tgt_age)
                     age_ff[i] <= age_ff[i] + 1'b1;
               end
               if (do_fill || do_touch) age_ff[tgt] <= '0;
               unique case (cmd_ff)
                  CMD_READ: begin
                     if (do_fill) begin
                        valid_ff[tgt]  <= 1'b1;
                        pinned_ff[tgt] <= 1'b0;
                        dirty_ff[tgt]  <= 1'b0;
                     end else if (do_repl) begin
                        dirty_ff[tgt] <= 1'b0;
                     end
                  end
                  CMD_WRITE: if (hit_ff) dirty_ff[tgt] <= 1'b1;
                  CMD_PIN, CMD_UNPIN: if (hit_ff) pinned_ff[tgt] <= (cmd_ff == CMD_PIN);
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("ready while response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
      else $error("response dropped under stall");
   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ST_REPL_DIRTY |-> rsp.victim_file == '0)
      else $error("victim tag without dirty replace");
   a_fill_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPDATE && do_fill |=> valid_ff[$past(tgt)])
      else $error("fill did not set valid");
endmodule
`default_nettype wire

// ----- bench/lru_buffer_pool_tags_checker.sv -----
`timescale 1ns / 100ps
module lru_buffer_pool_tags_checker
   import lbpt_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   lbpt_req_if.sink   req,
   lbpt_rsp_if.sink   rsp,
   output int errors,
   output int pending
);
   localparam int NSLOT = SLOTS_DEFAULT;

   typedef struct packed {
      status_type status;
      logic [SLOT_W-1:0] slot;
      logic [FILE_W-1:0] victim_file;
      logic [BLOCK_W-1:0] victim_block;
   } outcome_type;

   logic pool_valid [NSLOT];
   logic pool_pinned [NSLOT];
   logic pool_dirty [NSLOT];
   logic [FILE_W-1:0] pool_file [NSLOT];
   logic [BLOCK_W-1:0] pool_block [NSLOT];
   int pool_age [NSLOT];
   outcome_type outcome_q[$];

   assign pending = outcome_q.size();

   function automatic void make_recent(int s);
      int a;
      a = pool_age[s];
      for (int i = 0; i < NSLOT; i++)
         if (pool_valid[i] && i != s && pool_age[i] < a) pool_age[i]++;
      pool_age[s] = 0;
   endfunction

   function automatic outcome_type apply_command(cmd_type c, logic [FILE_W-1:0] f,
                                                 logic [BLOCK_W-1:0] b);
      outcome_type o;
      int hit;
      int pick;
      o = '0;
      hit = -1;
      pick = -1;
      for (int i = NSLOT - 1; i >= 0; i--)
         if (pool_valid[i] && pool_file[i] == f && pool_block[i] == b) hit = i;
      case (c)
         CMD_READ: begin
            if (hit >= 0) begin
               make_recent(hit);
               o.status = ST_READ_HIT;
               o.slot = SLOT_W'(hit);
            end else begin
               for (int i = NSLOT - 1; i >= 0; i--)
                  if (!pool_valid[i]) pick = i;
               if (pick >= 0) begin
                  for (int i = 0; i < NSLOT; i++)
                     if (pool_valid[i]) pool_age[i]++;
                  pool_valid[pick] = 1;
                  pool_file[pick] = f;
                  pool_block[pick] = b;
                  pool_pinned[pick] = 0;
                  pool_dirty[pick] = 0;
                  pool_age[pick] = 0;
                  o.status = ST_FILL_FREE;
                  o.slot = SLOT_W'(pick);
               end else begin
                  for (int i = 0; i < NSLOT; i++)
                     if (!pool_pinned[i] && (pick < 0 || pool_age[i] > pool_age[pick]))
                        pick = i;
                  if (pick < 0) begin
                     o.status = ST_ALL_PINNED;
                  end else begin
                     if (pool_dirty[pick]) begin
                        o.status = ST_REPL_DIRTY;
                        o.victim_file = pool_file[pick];
                        o.victim_block = pool_block[pick];
                     end else begin
                        o.status = ST_REPL_CLEAN;
                     end
                     make_recent(pick);
                     pool_file[pick] = f;
                     pool_block[pick] = b;
                     pool_dirty[pick] = 0;
                     o.slot = SLOT_W'(pick);
                  end
               end
            end
         end
         CMD_WRITE: begin
            if (hit >= 0) begin
               pool_dirty[hit] = 1;
               o.status = ST_WRITE_HIT;
               o.slot = SLOT_W'(hit);
            end else begin
               o.status = ST_WRITE_THRU;
            end
         end
         default: begin
            if (hit >= 0) begin
               if (c == CMD_PIN) begin
                  pool_pinned[hit] = 1;
               end else begin
                  pool_pinned[hit] = 0;
                  make_recent(hit);
               end
               o.status = ST_DONE;
               o.slot = SLOT_W'(hit);
            end else begin
               o.status = ST_NOT_FOUND;
            end
         end
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         errors = 0;
         outcome_q.delete();
         for (int i = 0; i < NSLOT; i++) begin
            pool_valid[i] = 0;
            pool_pinned[i] = 0;
            pool_dirty[i] = 0;
            pool_age[i] = 0;
         end
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (outcome_q.size() == 0) begin
               $error("response beat with nothing expected: status %0d", rsp.status);
               errors++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  errors++;
               end
               if (rsp.slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp.slot);
                  errors++;
               end
               if (rsp.victim_file !== want.victim_file) begin
                  $error("victim_file: expected %0h, got %0h", want.victim_file,
                         rsp.victim_file);
                  errors++;
               end
               if (rsp.victim_block !== want.victim_block) begin
                  $error("victim_block: expected %0h, got %0h", want.victim_block,
                         rsp.victim_block);
                  errors++;
               end
            end
         end
         if (req.valid && req.ready)
            outcome_q.push_back(apply_command(cmd_type'(req.command), req.file_id,
                                              req.block_number));
      end
   end
endmodule

// ----- bench/lru_buffer_pool_tags_tb.sv -----
`timescale 1ns / 100ps
module lru_buffer_pool_tags_tb;
   import lbpt_pkg::*;

   localparam int LIMIT = 400000;

   logic clock;
   logic reset;
   int errors;
   int pending;
   int cycle_count;
   bit long_hold;

   lbpt_req_if req ();
   lbpt_rsp_if rsp ();

   lru_buffer_pool_tags dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   lru_buffer_pool_tags_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .errors(errors), .pending(pending)
   );

   // small tag working set so hits, pins and replacements stay frequent
   logic [FILE_W-1:0] hot_file [24];
   logic [BLOCK_W-1:0] hot_block [24];

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > LIMIT) begin
            $display("lru_buffer_pool_tags_tb: FAIL");
            $finish;
         end
      end
   end

   // receiver: random stalls, quiet stretches, and one long hold-off
   initial begin
      int mode;
      bit hold_done;
      hold_done = 0;
      rsp.ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold && !hold_done) begin
            hold_done = 1;
            rsp.ready <= 0;
            repeat (300) @(posedge clock);
         end
         mode = (cycle_count / 2000) % 3;
         if (mode == 0) rsp.ready <= 1;
         else if (mode == 1) rsp.ready <= ($urandom_range(0, 3) != 0);
         else rsp.ready <= ($urandom_range(0, 1) != 0);
      end
   end

   task automatic send_beat(cmd_type c, logic [FILE_W-1:0] f, logic [BLOCK_W-1:0] b);
      req.valid <= 1;
      req.command <= c;
      req.file_id <= f;
      req.block_number <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic send_hot(cmd_type c, int k);
      send_beat(c, hot_file[k], hot_block[k]);
   endtask

   task automatic idle_cycles(int n);
      req.valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      int burst;
      int k;
      int pick;
      cmd_type c;
      long_hold = 0;
      reset = 1;
      req.valid = 0;
      req.command = CMD_READ;
      req.file_id = 0;
      req.block_number = 0;
      for (int i = 0; i < 24; i++) begin
         hot_file[i] = FILE_W'($urandom);
         hot_block[i] = BLOCK_W'($urandom);
      end
      hot_file[0] = '0;
      hot_block[0] = '0;
      hot_file[1] = '1;
      hot_block[1] = '1;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: misses on empty pool, fills, hits, write, pin all, replace
      send_hot(CMD_WRITE, 0);
      send_hot(CMD_PIN, 0);
      send_hot(CMD_UNPIN, 1);
      send_hot(CMD_READ, 0);
      send_hot(CMD_READ, 1);
      send_hot(CMD_READ, 0);
      send_hot(CMD_WRITE, 1);
      for (int i = 2; i < 16; i++) send_hot(CMD_READ, i);
      for (int i = 0; i < 16; i++) send_hot(CMD_PIN, i);
      send_hot(CMD_READ, 16);
      send_hot(CMD_UNPIN, 1);
      send_hot(CMD_READ, 17);
      send_hot(CMD_UNPIN, 3);
      send_hot(CMD_READ, 18);
      for (int i = 0; i < 16; i++) send_hot(CMD_UNPIN, i);

      // wait for outstanding responses to drain before the random part
      idle_cycles(1);
      while (pending != 0) @(posedge clock);

      for (int n = 0; n < 1300; n++) begin
         if (n == 400) long_hold = 1;
         if (n == 800) begin
            idle_cycles(1);
            while (pending != 0) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         c = cmd_type'($urandom_range(0, 3));
         if (pick < 4) begin
            send_beat(c, FILE_W'($urandom), BLOCK_W'($urandom));
         end else begin
            // mostly reads, fewer pins so the pool rarely locks up for long
            k = $urandom_range(0, 23);
            if (pick < 50) c = CMD_READ;
            else if (pick < 70) c = CMD_WRITE;
            else if (pick < 82) c = CMD_UNPIN;
            else if (pick < 92) c = CMD_PIN;
            send_hot(c, k);
         end
         if ((n % 50) == 0) burst = $urandom_range(0, 6);
         if (burst != 0 && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 30));
      end
      idle_cycles(1);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("lru_buffer_pool_tags_tb: PASS");
      end else begin
         $display("lru_buffer_pool_tags_tb: FAIL");
      end
      $finish;
   end
endmodule
